// ----- rtl/pcrd_pkg.sv -----
// Shared types and constants of the per-type count release debouncer.
package pcrd_pkg;

    // Field and port widths, and the largest table the type field can address
    localparam int TYPE_W     = 4;
    localparam int COUNT_W    = 8;
    localparam int TIME_W     = 32;
    localparam int GRACE_W    = 16;
    localparam int MAX_TYPES  = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_ADDR_W = 1;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 24;

    // Register reset values
    localparam logic [GRACE_W-1:0]   GRACE_RESET = 16'd2000;
    localparam logic [MAX_TYPES-1:0] MASK_RESET  = 16'hFFFE;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_GRACE = 1'b0,
        CFG_MASK  = 1'b1
    } pcrd_cfg_addr_t;

    // Item opcodes
    typedef enum logic [1:0] {
        OP_REPORT = 2'd0,
        OP_EOR    = 2'd1,
        OP_TICK   = 2'd2,
        OP_QUERY  = 2'd3
    } pcrd_op_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REPORT,
        ST_SCAN_EOR,
        ST_SCAN_TICK,
        ST_RESULT
    } pcrd_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic upd_report;
        logic upd_eor;
        logic upd_tick;
        logic out_load;
    } pcrd_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic scan_last;
        logic out_full;
    } pcrd_status_t;

endpackage

// ----- rtl/pcrd_ctrl.sv -----
// Controller state machine: sequences report, scan and result steps of one item.
module pcrd_ctrl
    import pcrd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  pcrd_op_t     in_op,
    output logic         in_ready,
    input  pcrd_status_t status,
    output pcrd_cmd_t    cmd
);

    pcrd_state_t state_reg;
    pcrd_state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance the state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_op)
                        OP_REPORT: state_next = ST_REPORT;
                        OP_EOR:    state_next = ST_SCAN_EOR;
                        OP_TICK:   state_next = ST_SCAN_TICK;
                        OP_QUERY:  state_next = ST_RESULT;
                        default:   state_next = ST_RESULT;
                    endcase
                end
            end
            ST_REPORT:
            begin
                state_next = ST_RESULT;
            end
            ST_SCAN_EOR, ST_SCAN_TICK:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!status.out_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Drive the commands
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_REPORT:
            begin
                cmd.upd_report = 1'b1;
            end
            ST_SCAN_EOR:
            begin
                cmd.upd_eor = 1'b1;
            end
            ST_SCAN_TICK:
            begin
                cmd.upd_tick = 1'b1;
            end
            ST_RESULT:
            begin
                cmd.out_load = !status.out_full;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/pcrd_dp.sv -----
// Datapath: item capture, per-type table, entry update logic and result register.
module pcrd_dp
    import pcrd_pkg::*;
#(
    parameter int NUM_TYPES = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata,
    input  logic [IN_DATA_W-1:0]    in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [OUT_DATA_W-1:0]   out_data,
    input  pcrd_cmd_t               cmd,
    output pcrd_status_t            status
);

    // Only types below sixteen can ever be valid, so the table stops there
    localparam int TBL  = (NUM_TYPES < MAX_TYPES) ? NUM_TYPES : MAX_TYPES;
    localparam int IDXW = $clog2(TBL);
    localparam logic [TYPE_W:0]   TBL_L  = (TYPE_W + 1)'(TBL);
    localparam logic [IDXW-1:0]   LAST_I = IDXW'(TBL - 1);

    // Configuration registers
    logic [GRACE_W-1:0]   grace_reg;
    logic [MAX_TYPES-1:0] mask_reg;

    // Captured item
    pcrd_op_t            op_reg;
    logic [TYPE_W-1:0]   type_reg;
    logic [COUNT_W-1:0]  rcnt_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [IDXW-1:0]     scan_reg;

    // Table
    logic [COUNT_W-1:0]  count_reg   [TBL];
    logic                known_reg   [TBL];
    logic                pend_reg    [TBL];
    logic                seen_reg    [TBL];
    logic [COUNT_W-1:0]  target_reg  [TBL];
    logic [TIME_W-1:0]   start_reg   [TBL];

    // Result register
    logic                  ovalid_reg;
    logic [OUT_DATA_W-1:0] odata_reg;

    // Entry access
    logic [IDXW-1:0]     addr;
    logic                scanning;
    logic                in_table;
    logic                type_ok;
    logic                e_valid;
    logic [COUNT_W-1:0]  e_count;
    logic                e_known;
    logic                e_pend;
    logic                e_seen;
    logic [COUNT_W-1:0]  e_target;
    logic [TIME_W-1:0]   e_start;
    logic [COUNT_W-1:0]  count_next;
    logic                known_next;
    logic                pend_next;
    logic                seen_next;
    logic [COUNT_W-1:0]  target_next;
    logic [TIME_W-1:0]   start_next;
    logic                stage;
    logic [TIME_W-1:0]   age;
    logic                entry_we;

    // Hold the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grace_reg <= GRACE_RESET;
            mask_reg  <= MASK_RESET;
        end
        else if (cfg_we)
        begin
            case (pcrd_cfg_addr_t'(cfg_addr))
                CFG_GRACE: grace_reg <= cfg_wdata;
                CFG_MASK:  mask_reg  <= cfg_wdata;
                default:   grace_reg <= grace_reg;
            endcase
        end
    end

    // Capture the item
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= pcrd_op_t'(in_data[1:0]);
            type_reg <= in_data[5:2];
            rcnt_reg <= in_data[13:6];
            now_reg  <= in_data[45:14];
        end
    end

    // Advance the scan index, restart it with each item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
        end
        else if (cmd.load)
        begin
            scan_reg <= '0;
        end
        else if (cmd.upd_eor || cmd.upd_tick)
        begin
            scan_reg <= scan_reg + 1'b1;
        end
    end

    assign scanning = cmd.upd_eor || cmd.upd_tick;
    assign addr     = scanning ? scan_reg : type_reg[IDXW-1:0];
    assign in_table = ({1'b0, type_reg} < TBL_L);
    assign type_ok  = in_table && mask_reg[type_reg];
    assign e_valid  = mask_reg[TYPE_W'(addr)];

    // Read the addressed entry
    assign e_count  = count_reg[addr];
    assign e_known  = known_reg[addr];
    assign e_pend   = pend_reg[addr];
    assign e_seen   = seen_reg[addr];
    assign e_target = target_reg[addr];
    assign e_start  = start_reg[addr];

    // Work out the entry update for the current step
    always_comb
    begin
        count_next  = e_count;
        known_next  = e_known;
        pend_next   = e_pend;
        seen_next   = e_seen;
        target_next = e_target;
        start_next  = e_start;
        stage       = 1'b0;
        age         = '0;
        if (cmd.upd_report)
        begin
            seen_next = 1'b1;
            if (!e_known)
            begin
                known_next = 1'b1;
                count_next = rcnt_reg;
                pend_next  = 1'b0;
            end
            else if (rcnt_reg > e_count)
            begin
                count_next = rcnt_reg;
                pend_next  = 1'b0;
            end
            else if (rcnt_reg < e_count)
            begin
                if (!e_pend || (e_target != rcnt_reg))
                begin
                    pend_next   = 1'b1;
                    target_next = rcnt_reg;
                    start_next  = now_reg;
                end
            end
        end
        else
        begin
            // Stage a drop to zero for a type missing from the report
            stage = cmd.upd_eor && e_known && e_valid && !e_seen && (e_count != '0)
                    && !(e_pend && (e_target == '0));
            if (stage)
            begin
                pend_next   = 1'b1;
                target_next = '0;
                start_next  = now_reg;
            end
            // Commit a decrease that has waited out the grace time
            age = now_reg - start_next;
            if (pend_next && (age >= {{(TIME_W - GRACE_W){1'b0}}, grace_reg}))
            begin
                count_next = target_next;
                pend_next  = 1'b0;
            end
            // Forget a type that is no longer accepted, drop seen marks
            if (cmd.upd_eor)
            begin
                if (e_known && !e_valid)
                begin
                    known_next = 1'b0;
                    count_next = '0;
                    pend_next  = 1'b0;
                end
                seen_next = 1'b0;
            end
        end
    end

    assign entry_we = (cmd.upd_report && type_ok) || scanning;

    // Hold the table flags and counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TBL; i++)
            begin
                count_reg[i] <= '0;
                known_reg[i] <= 1'b0;
                pend_reg[i]  <= 1'b0;
                seen_reg[i]  <= 1'b0;
            end
        end
        else if (entry_we)
        begin
            count_reg[addr] <= count_next;
            known_reg[addr] <= known_next;
            pend_reg[addr]  <= pend_next;
            seen_reg[addr]  <= seen_next;
        end
    end

    // Hold pending targets and start times, meaningful only while pending
    always_ff @(posedge clk)
    begin
        if (entry_we)
        begin
            target_reg[addr] <= target_next;
            start_reg[addr]  <= start_next;
        end
    end

    // Load the result item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            odata_reg <= {1'b0,
                          (op_reg == OP_REPORT) && !type_ok,
                          (in_table && e_pend) ? e_target : {COUNT_W{1'b0}},
                          in_table && e_pend,
                          in_table && e_known,
                          in_table ? e_count : {COUNT_W{1'b0}},
                          type_reg};
        end
    end

    assign out_valid        = ovalid_reg;
    assign out_data         = odata_reg;
    assign status.out_full  = ovalid_reg && !out_ready;
    assign status.scan_last = (scan_reg == LAST_I);

endmodule

// ----- rtl/per_type_count_release_debouncer.sv -----
// Top level of the per-type count release debouncer.
// Keeps one committed device count per device type (up to sixteen types): a
// rise or a first report applies at once, a fall waits grace_time_ms before it
// commits, and a known type missing from a report is staged to fall to zero.
// Each input item gives exactly one result item describing its device type.
// A report entry passes an update state and then the result state; a query
// goes straight to the result state; end of report and tick first scan the
// table, updating one type entry per cycle over min(NUM_TYPES, 16) entries.
// The next item is accepted in the cycle after the previous one has moved
// into the result register, so no new item is taken before the last is done,
// and the result step waits while a held result is not taken on m_tready.
// Configuration writes are taken at any edge with cfg_we high and are meant to
// happen only while idle.
module per_type_count_release_debouncer
    import pcrd_pkg::*;
#(
    parameter int NUM_TYPES = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // command[1:0], device_type[5:2], reported_count[13:6], now_ms[45:14], zero[47:46]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // Result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // echo_type[3:0], committed_count[11:4], type_known[12], decrease_pending[13],
    // pending_count[21:14], rejected[22], zero[23]
    output logic [OUT_DATA_W-1:0] m_tdata
);

    pcrd_cmd_t    cmd;
    pcrd_status_t status;

    pcrd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_op    (pcrd_op_t'(s_tdata[1:0])),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pcrd_dp #(
        .NUM_TYPES (NUM_TYPES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ----- tb/tb_per_type_count_release_debouncer.sv -----
// Self-checking testbench of the per-type count release debouncer.
`timescale 1ns / 100ps

import pcrd_pkg::*;

// One result item split into its fields
typedef struct {
    logic [3:0] echo_type;
    logic [7:0] committed_count;
    logic       type_known;
    logic       decrease_pending;
    logic [7:0] pending_count;
    logic       rejected;
} type_status_t;

// Scoreboard: predicts the per-type table and holds the status items still due
class count_release_model;
    logic [15:0]  grace;
    logic [15:0]  mask;
    logic [7:0]   count_tab [16];
    bit           known [16];
    bit           pend [16];
    bit           seen [16];
    logic [7:0]   target [16];
    logic [31:0]  start [16];
    type_status_t due_status [$];
    int           errors;

    function new();
        grace  = GRACE_RESET;
        mask   = MASK_RESET;
        errors = 0;
        for (int t = 0; t < 16; t++)
        begin
            count_tab[t] = '0;
            known[t]     = 0;
            pend[t]      = 0;
            seen[t]      = 0;
            target[t]    = '0;
            start[t]     = '0;
        end
    endfunction

    function int outstanding();
        return due_status.size();
    endfunction

    // Commit every decrease that has waited out the grace time
    function void commit_due(logic [31:0] now_ms);
        logic [31:0] age;
        for (int t = 0; t < 16; t++)
        begin
            age = now_ms - start[t];
            if (pend[t] && age >= {16'd0, grace})
            begin
                count_tab[t] = target[t];
                pend[t]      = 0;
            end
        end
    endfunction

    // Apply one accepted item and queue the status it must produce
    function void note_item(pcrd_op_t op, logic [3:0] t, logic [7:0] cnt, logic [31:0] now_ms);
        type_status_t st;
        st.rejected = 1'b0;
        case (op)
            OP_REPORT:
            begin
                if (!mask[t])
                    st.rejected = 1'b1;
                else
                begin
                    seen[t] = 1;
                    if (!known[t])
                    begin
                        known[t]     = 1;
                        count_tab[t] = cnt;
                        pend[t]      = 0;
                    end
                    else if (cnt > count_tab[t])
                    begin
                        count_tab[t] = cnt;
                        pend[t]      = 0;
                    end
                    else if (cnt < count_tab[t] && (!pend[t] || target[t] != cnt))
                    begin
                        pend[t]   = 1;
                        target[t] = cnt;
                        start[t]  = now_ms;
                    end
                end
            end
            OP_EOR:
            begin
                // Stage missing types to zero, commit, then forget disabled types
                for (int i = 0; i < 16; i++)
                begin
                    if (known[i] && mask[i] && !seen[i] && count_tab[i] != 0 &&
                        !(pend[i] && target[i] == 0))
                    begin
                        pend[i]   = 1;
                        target[i] = '0;
                        start[i]  = now_ms;
                    end
                end
                commit_due(now_ms);
                for (int i = 0; i < 16; i++)
                begin
                    if (known[i] && !mask[i])
                    begin
                        known[i]     = 0;
                        count_tab[i] = '0;
                        pend[i]      = 0;
                    end
                    seen[i] = 0;
                end
            end
            OP_TICK:
                commit_due(now_ms);
            default:
                ;
        endcase
        st.echo_type        = t;
        st.committed_count  = count_tab[t];
        st.type_known       = known[t];
        st.decrease_pending = pend[t];
        st.pending_count    = pend[t] ? target[t] : 8'd0;
        due_status.insert(due_status.size(), st);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Compare one result item with the oldest status still due
    function void check_result(logic [OUT_DATA_W-1:0] data);
        type_status_t want;
        if (due_status.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result item, expected none, actual %h", $time, data);
        end
        else
        begin
            want = due_status.pop_front();
            compare_field("echo_type", 32'(want.echo_type), 32'(data[3:0]));
            compare_field("committed_count", 32'(want.committed_count), 32'(data[11:4]));
            compare_field("type_known", 32'(want.type_known), 32'(data[12]));
            compare_field("decrease_pending", 32'(want.decrease_pending), 32'(data[13]));
            compare_field("pending_count", 32'(want.pending_count), 32'(data[21:14]));
            compare_field("rejected", 32'(want.rejected), 32'(data[22]));
        end
    endfunction
endclass

module tb_per_type_count_release_debouncer;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int NUM_PHASES  = 6;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    count_release_model sb;
    int                 src_idle_pct;
    int                 sink_idle_pct;
    int                 hold_requests;
    int                 items_sent;
    logic [31:0]        clock_ms;

    per_type_count_release_debouncer #(.NUM_TYPES(16)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Drive result ready: random stalls plus long hold-offs on request
    initial
    begin
        int hold_left;
        int holds_taken;
        hold_left   = 0;
        holds_taken = 0;
        m_tready    = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_taken != hold_requests)
            begin
                holds_taken = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Check each result item as it is taken
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // End the run when no item moves for too long
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("tb_per_type_count_release_debouncer: errors");
                $finish;
            end
        end
    end

    // Offer one item and hold it until it is accepted
    task automatic send_item(pcrd_op_t op, logic [3:0] t, logic [7:0] cnt, logic [31:0] now_ms);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, now_ms, cnt, t, op};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_item(op, t, cnt, now_ms);
        items_sent++;
    endtask

    // Stop offering and wait until every result item is back
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    task automatic write_cfg(pcrd_cfg_addr_t addr, logic [15:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (addr == CFG_GRACE)
            sb.grace = value;
        else
            sb.mask = value;
    endtask

    // Advance the millisecond clock, mostly in steps well below the grace time
    function automatic void advance_clock();
        if ($urandom_range(9) == 0)
            clock_ms += $urandom_range(2 * sb.grace + 10);
        else
            clock_ms += $urandom_range(sb.grace / 4 + 3);
    endfunction

    // One report: one to six entries with an occasional query, end of report, then up to two ticks; or a noise item
    task automatic random_round();
        int         n;
        logic [3:0] t;
        logic [7:0] c;
        if ($urandom_range(99) < 15)
            send_item(pcrd_op_t'($urandom_range(3)), 4'($urandom_range(15)),
                      8'($urandom_range(255)), $urandom);
        else
        begin
            n = $urandom_range(1, 6);
            repeat (n)
            begin
                t = 4'($urandom_range(15));
                if (!sb.mask[t] && $urandom_range(3) != 0)
                    t = 4'($urandom_range(15));
                // Favor equal, lower and same-target counts
                case ($urandom_range(3))
                    0: c = sb.count_tab[t];
                    1: c = (sb.count_tab[t] == 0) ? 8'd0 :
                           8'($urandom_range(32'(sb.count_tab[t]) - 1));
                    2: c = sb.target[t];
                    default: c = 8'($urandom_range(255));
                endcase
                advance_clock();
                send_item(OP_REPORT, t, c, clock_ms);
                if ($urandom_range(9) == 0)
                begin
                    advance_clock();
                    send_item(OP_QUERY, 4'($urandom_range(15)), 8'($urandom_range(255)),
                              clock_ms);
                end
            end
            advance_clock();
            send_item(OP_EOR, 4'($urandom_range(15)), 8'($urandom_range(255)), clock_ms);
            repeat ($urandom_range(2))
            begin
                advance_clock();
                send_item(OP_TICK, 4'($urandom_range(15)), 8'($urandom_range(255)), clock_ms);
            end
        end
    endtask

    initial
    begin
        logic [15:0] phase_grace [NUM_PHASES];
        logic [15:0] phase_mask [NUM_PHASES];
        int          phase_items [NUM_PHASES];
        int          phase_end;
        bit          paused_once;

        sb            = new();
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        src_idle_pct  = 33;
        sink_idle_pct = 62;
        hold_requests = 0;
        items_sent    = 0;
        clock_ms      = '0;
        paused_once   = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        // Directed items under the reset settings
        send_item(OP_QUERY, 4'd0, 8'd0, 32'd0);
        send_item(OP_REPORT, 4'd0, 8'd5, 32'd0);            // type zero disabled
        send_item(OP_REPORT, 4'd15, 8'd255, 32'd0);         // first report applies
        send_item(OP_REPORT, 4'd3, 8'd0, 32'd0);
        send_item(OP_REPORT, 4'd15, 8'd255, 32'd5);         // equal count
        send_item(OP_REPORT, 4'd7, 8'd10, 32'd10);
        send_item(OP_REPORT, 4'd7, 8'd4, 32'd20);           // lower count staged
        send_item(OP_REPORT, 4'd7, 8'd4, 32'd30);           // same target keeps timer
        send_item(OP_REPORT, 4'd7, 8'd2, 32'd40);           // new target restarts timer
        send_item(OP_REPORT, 4'd7, 8'd20, 32'd50);          // rise cancels decrease
        send_item(OP_REPORT, 4'd7, 8'd20, 32'd60);
        send_item(OP_REPORT, 4'd15, 8'd100, 32'd70);
        send_item(OP_REPORT, 4'd7, 8'd5, 32'd100);
        send_item(OP_EOR, 4'd15, 8'd0, 32'd1000);
        send_item(OP_EOR, 4'd7, 8'd0, 32'd1500);            // missing types go to zero
        send_item(OP_EOR, 4'd15, 8'd0, 32'd2000);           // zero already waiting
        send_item(OP_TICK, 4'd15, 8'd255, 32'd3499);
        send_item(OP_TICK, 4'd7, 8'd0, 32'd3500);           // expiry commits
        send_item(OP_QUERY, 4'd15, 8'd255, 32'hFFFF_FFFF);
        send_item(OP_REPORT, 4'd9, 8'd8, 32'hFFFF_FF00);
        send_item(OP_REPORT, 4'd9, 8'd1, 32'hFFFF_FFF0);
        send_item(OP_TICK, 4'd9, 8'd0, 32'h0000_07BF);      // wrapped age one short
        send_item(OP_TICK, 4'd9, 8'd0, 32'h0000_07C0);      // wrapped age reaches grace
        send_item(OP_QUERY, 4'd9, 8'd0, 32'h0000_07C0);
        drain();

        // Settings per random phase, extremes included
        phase_grace = '{16'd3, 16'd65535, 16'd0, 16'd50, 16'd1000, 16'($urandom_range(65535))};
        phase_mask  = '{16'hFFFF, 16'h0000, 16'($urandom_range(65535)),
                        16'($urandom_range(65535)), 16'hFFFF, 16'($urandom_range(65535))};
        phase_items = '{170, 40, 170, 170, 170, 170};

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_cfg(CFG_GRACE, phase_grace[p]);
            write_cfg(CFG_MASK, phase_mask[p]);
            case (p / 2)
                0:
                begin
                    src_idle_pct  = 33;
                    sink_idle_pct = 62;
                end
                1:
                begin
                    src_idle_pct  = 62;
                    sink_idle_pct = 33;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            if (p == 3)
                clock_ms = 32'hFFFF_FFFF - $urandom_range(5000);
            else
                clock_ms = $urandom;
            // Long receiver hold-off while items keep coming
            if (p == 0 || p == 4)
                hold_requests++;
            phase_end = items_sent + phase_items[p];
            while (items_sent < phase_end)
            begin
                random_round();
                if (p == 0 && !paused_once && items_sent >= phase_end - 80)
                begin
                    drain();
                    paused_once = 1;
                end
            end
            drain();
        end

        repeat (30) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("tb_per_type_count_release_debouncer: clean");
        else
            $display("tb_per_type_count_release_debouncer: errors");
        $finish;
    end

endmodule
